/* design/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // io field width and widened off-diagonal numerator width
  localparam int FIELD_W = 18;
  localparam int NUM_W   = 19;

  // branch codes
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // per-word sideband carried alongside the square root
  typedef struct packed {
    logic [1:0]              br;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } rmq_side_t;

endpackage

/* design/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// Branch choice, radicand with clamp, and selection of the three numerators.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int FB = 16,
  parameter int RW = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [rmq_pkg::FIELD_W-1:0] m00,
  input  logic signed [rmq_pkg::FIELD_W-1:0] m01,
  input  logic signed [rmq_pkg::FIELD_W-1:0] m02,
  input  logic signed [rmq_pkg::FIELD_W-1:0] m10,
  input  logic signed [rmq_pkg::FIELD_W-1:0] m11,
  input  logic signed [rmq_pkg::FIELD_W-1:0] m12,
  input  logic signed [rmq_pkg::FIELD_W-1:0] m20,
  input  logic signed [rmq_pkg::FIELD_W-1:0] m21,
  input  logic signed [rmq_pkg::FIELD_W-1:0] m22,
  output logic                              out_valid,
  output logic [2*RW-1:0]                   radicand,
  output rmq_pkg::rmq_side_t                side
);
  import rmq_pkg::*;

  localparam logic signed [32:0] ONE = 33'sd1 <<< FB;

  logic signed [19:0]      trace;
  logic signed [32:0]      rad_raw;
  logic [31:0]             rad_pos;
  logic signed [NUM_W-1:0] d0, d1, d2, s01, s02, s12;
  rmq_side_t               side_next;

  // diagonal sums and branch selection
  always_comb begin
    trace = 20'(m00) + 20'(m11) + 20'(m22);
    d0  = NUM_W'(m21) - NUM_W'(m12);
    d1  = NUM_W'(m02) - NUM_W'(m20);
    d2  = NUM_W'(m10) - NUM_W'(m01);
    s01 = NUM_W'(m01) + NUM_W'(m10);
    s02 = NUM_W'(m02) + NUM_W'(m20);
    s12 = NUM_W'(m12) + NUM_W'(m21);
    if (trace > 20'sd0) begin
      side_next.br = BR_TRACE;
      rad_raw = ONE + 33'(trace);
      side_next.n0 = d0;
      side_next.n1 = d1;
      side_next.n2 = d2;
    end else if (m00 > m11 && m00 > m22) begin
      side_next.br = BR_X;
      rad_raw = ONE + 33'(m00) - 33'(m11) - 33'(m22);
      side_next.n0 = d0;
      side_next.n1 = s01;
      side_next.n2 = s02;
    end else if (m11 > m22) begin
      side_next.br = BR_Y;
      rad_raw = ONE + 33'(m11) - 33'(m00) - 33'(m22);
      side_next.n0 = d1;
      side_next.n1 = s01;
      side_next.n2 = s12;
    end else begin
      side_next.br = BR_Z;
      rad_raw = ONE + 33'(m22) - 33'(m00) - 33'(m11);
      side_next.n0 = d2;
      side_next.n1 = s02;
      side_next.n2 = s12;
    end
    // clamp non-positive radicand to one lsb
    if (rad_raw <= 33'sd0) begin
      rad_pos = 32'd1;
    end else begin
      rad_pos = rad_raw[31:0];
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radicand <= (2*RW)'(rad_pos) << FB;
      side     <= side_next;
    end
  end

endmodule

/* design/rmq_sqrt.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int RW = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] radicand,
  output logic            out_valid,
  output logic [RW-1:0]   root
);

  logic [RW:1]     vld;
  logic [2*RW-1:0] vsh [1:RW];
  logic [RW+1:0]   rem [1:RW];
  logic [RW-1:0]   res [1:RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic            v_in;
    logic [2*RW-1:0] sh_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   res_in;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    // stage inputs from the port or from the previous stage
    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign sh_in  = radicand;
      assign rem_in = '0;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = vld[i];
      assign sh_in  = vsh[i];
      assign rem_in = rem[i];
      assign res_in = res[i];
    end

    // bring in two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_in[RW:0], sh_in[2*RW-1 -: 2]};
      trial  = {1'b0, res_in, 2'b01};
      ge     = rem_sh >= trial;
      diff   = rem_sh - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vsh[i+1] <= sh_in << 2;
        rem[i+1] <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        res[i+1] <= {res_in[RW-2:0], ge};
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = res[RW];

endmodule

/* design/rmq_div.sv */
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider for num * 2^FB / den, one quotient bit per
// stage, with overrange detect for quotients at or above 2^(FB+2).
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int FB = 16,
  parameter int DW = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [rmq_pkg::NUM_W-1:0] num,
  input  logic [DW-1:0]                    den,
  output logic                             out_valid,
  output logic [FB+1:0]                    quo,
  output logic                             sat,
  output logic                             neg
);
  import rmq_pkg::*;

  localparam int QB = FB + 2;
  localparam int NW = NUM_W + FB;
  localparam int CW = DW + NW + 2;

  logic [QB:0]     vld;
  logic [NW-1:0]   rem  [QB+1];
  logic [DW-1:0]   dv   [QB+1];
  logic [QB-1:0]   q    [QB+1];
  logic [QB:0]     sv;
  logic [QB:0]     nv;
  logic [NUM_W-1:0] mag;

  // magnitude, sign and overrange check
  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= NW'(mag) << FB;
      dv[0]  <= den;
      q[0]   <= '0;
      sv[0]  <= (CW'(mag) >= (CW'(den) << 2));
      nv[0]  <= num[NUM_W-1];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int K = QB - 1 - j;
    logic [CW-1:0] shd;
    logic [CW-1:0] diff;
    logic          ge;

    // compare against the shifted divisor for quotient bit K
    always_comb begin
      shd  = CW'(dv[j]) << K;
      ge   = CW'(rem[j]) >= shd;
      diff = CW'(rem[j]) - shd;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? diff[NW-1:0] : rem[j];
        dv[j+1]  <= dv[j];
        q[j+1]   <= {q[j][QB-2:0], ge};
        sv[j+1]  <= sv[j];
        nv[j+1]  <= nv[j];
      end
    end
  end

  assign out_valid = vld[QB];
  assign quo       = q[QB];
  assign sat       = sv[QB];
  assign neg       = nv[QB];

endmodule

/* design/rmq_delay.sv */
// ----------------------------------------------------------------------------
// rmq_delay
// Enabled shift line that keeps sideband data aligned with a pipeline.
// ----------------------------------------------------------------------------
module rmq_delay #(
  parameter int DEPTH = 4,
  parameter int W     = 8
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap [DEPTH];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[DEPTH-1];

endmodule

/* design/rotation_matrix_to_quaternion.sv */
// Throughput: one word per cycle; the whole pipeline advances together and
// holds in place while the output register is full and not taken.
// Depth is set by the bit-per-stage square root followed by the
// bit-per-stage dividers. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion by Shepperd's method in fixed point.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r0c0,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r0c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r0c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r1c0,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r1c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r1c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r2c0,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r2c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r2c2,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rmq_pkg::FIELD_W-1:0] quat_w,
  output logic signed [rmq_pkg::FIELD_W-1:0] quat_x,
  output logic signed [rmq_pkg::FIELD_W-1:0] quat_y,
  output logic signed [rmq_pkg::FIELD_W-1:0] quat_z,
  output logic [1:0]                        branch_taken
);
  import rmq_pkg::*;

  localparam int FB  = FRAC_BITS;
  localparam int RW  = (FB + 32) / 2;
  localparam int DW  = RW + 1;
  localparam int SBW = $bits(rmq_side_t);
  localparam int TW  = RW + 2;
  localparam logic [FB+1:0] ONE_Q = (FB+2)'(1) << FB;
  localparam logic [RW-1:0] ONE_R = RW'(1) << FB;

  logic                en;
  logic                f_valid;
  logic [2*RW-1:0]     radicand;
  rmq_side_t           f_side;
  rmq_side_t           s_side;
  logic [SBW-1:0]      s_side_bits;
  logic                s_valid;
  logic [RW-1:0]       root;
  logic [DW-1:0]       den;
  logic [TW-1:0]       tail_in;
  logic [TW-1:0]       tail_out;
  logic [1:0]          d_br;
  logic [RW-1:0]       d_big;
  logic [2:0]          d_valid;
  logic [FB+1:0]       d_quo [3];
  logic [2:0]          d_sat;
  logic [2:0]          d_neg;
  logic [FIELD_W-1:0]  comp [3];
  logic [FIELD_W-1:0]  big_fld;

  // the pipeline moves whenever the output register can take a word
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rmq_front #(.FB(FB), .RW(RW)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .m00(elem_r0c0), .m01(elem_r0c1), .m02(elem_r0c2),
    .m10(elem_r1c0), .m11(elem_r1c1), .m12(elem_r1c2),
    .m20(elem_r2c0), .m21(elem_r2c1), .m22(elem_r2c2),
    .out_valid(f_valid), .radicand(radicand), .side(f_side)
  );

  rmq_sqrt #(.RW(RW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .radicand(radicand), .out_valid(s_valid), .root(root)
  );

  rmq_delay #(.DEPTH(RW), .W(SBW)) u_side_dly (
    .clk(clk), .en(en), .din(f_side), .dout(s_side_bits)
  );

  assign s_side  = rmq_side_t'(s_side_bits);
  assign den     = {root, 1'b0};
  assign tail_in = {s_side.br, root >> 1};

  // three dividers for the non-dominant components
  rmq_div #(.FB(FB), .DW(DW)) u_div0 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .num(s_side.n0), .den(den),
    .out_valid(d_valid[0]), .quo(d_quo[0]), .sat(d_sat[0]), .neg(d_neg[0])
  );

  rmq_div #(.FB(FB), .DW(DW)) u_div1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .num(s_side.n1), .den(den),
    .out_valid(d_valid[1]), .quo(d_quo[1]), .sat(d_sat[1]), .neg(d_neg[1])
  );

  rmq_div #(.FB(FB), .DW(DW)) u_div2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .num(s_side.n2), .den(den),
    .out_valid(d_valid[2]), .quo(d_quo[2]), .sat(d_sat[2]), .neg(d_neg[2])
  );

  rmq_delay #(.DEPTH(FB + 3), .W(TW)) u_tail_dly (
    .clk(clk), .en(en), .din(tail_in), .dout(tail_out)
  );

  assign d_br  = tail_out[TW-1 -: 2];
  assign d_big = tail_out[RW-1:0];

  // saturate quotients to one and apply sign
  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic [FB+1:0]       mag;
    logic signed [FB+2:0] sval;
    logic signed [63:0]   wide;
    always_comb begin
      mag  = (d_sat[c] || d_quo[c] > ONE_Q) ? ONE_Q : d_quo[c];
      sval = d_neg[c] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      wide = 64'(sval);
      comp[c] = wide[FIELD_W-1:0];
    end
  end

  // dominant component is half the root, saturated
  always_comb begin
    logic [63:0] bw;
    bw = 64'((d_big > ONE_R) ? ONE_R : d_big);
    big_fld = bw[FIELD_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      branch_taken <= d_br;
      case (d_br)
        BR_TRACE: begin
          quat_w <= big_fld;  quat_x <= comp[0];
          quat_y <= comp[1];  quat_z <= comp[2];
        end
        BR_X: begin
          quat_w <= comp[0];  quat_x <= big_fld;
          quat_y <= comp[1];  quat_z <= comp[2];
        end
        BR_Y: begin
          quat_w <= comp[0];  quat_x <= comp[1];
          quat_y <= big_fld;  quat_z <= comp[2];
        end
        default: begin
          quat_w <= comp[0];  quat_x <= comp[1];
          quat_y <= comp[2];  quat_z <= big_fld;
        end
      endcase
    end
  end

endmodule

/* bench/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// Watches both channels of the matrix to quaternion block, predicts each
// quaternion and branch from the accepted matrix and compares in order.
// ----------------------------------------------------------------------------
module rmq_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r0c0,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r0c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r0c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r1c0,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r1c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r1c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r2c0,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r2c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] elem_r2c2,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [rmq_pkg::FIELD_W-1:0] quat_w,
  input  logic signed [rmq_pkg::FIELD_W-1:0] quat_x,
  input  logic signed [rmq_pkg::FIELD_W-1:0] quat_y,
  input  logic signed [rmq_pkg::FIELD_W-1:0] quat_z,
  input  logic [1:0]                         branch_taken,
  output int                                 fail_count,
  output int                                 pending_quats,
  output int                                 quat_count,
  output int                                 branch_hits [4]
);
  import rmq_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] w;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
    logic [1:0]         br;
  } quat_t;

  quat_t expected_quats[$];

  // integer square root, rounded down
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // clamp to plus or minus one, then cut to field width
  function automatic logic [FIELD_W-1:0] clamp_unit(longint v);
    longint one;
    one = longint'(1) << FRAC_BITS;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[FIELD_W-1:0];
  endfunction

  function automatic quat_t shepperd(longint m00, longint m01, longint m02,
                                     longint m10, longint m11, longint m12,
                                     longint m20, longint m21, longint m22);
    quat_t q;
    longint one, rad, big, den;
    longint c[4];
    logic [1:0] br;
    longint unsigned root;
    one = longint'(1) << FRAC_BITS;
    if (m00 + m11 + m22 > 0) begin
      br = BR_TRACE;
      rad = one + m00 + m11 + m22;
    end else if (m00 > m11 && m00 > m22) begin
      br = BR_X;
      rad = one + m00 - m11 - m22;
    end else if (m11 > m22) begin
      br = BR_Y;
      rad = one + m11 - m00 - m22;
    end else begin
      br = BR_Z;
      rad = one + m22 - m00 - m11;
    end
    if (rad <= 0) rad = 1;
    root = floor_sqrt(longint'(rad) << FRAC_BITS);
    big = longint'(root >> 1);
    den = longint'(root) * 2;
    case (br)
      BR_TRACE: begin
        c[0] = big;
        c[1] = ((m21 - m12) * one) / den;
        c[2] = ((m02 - m20) * one) / den;
        c[3] = ((m10 - m01) * one) / den;
      end
      BR_X: begin
        c[0] = ((m21 - m12) * one) / den;
        c[1] = big;
        c[2] = ((m01 + m10) * one) / den;
        c[3] = ((m02 + m20) * one) / den;
      end
      BR_Y: begin
        c[0] = ((m02 - m20) * one) / den;
        c[1] = ((m01 + m10) * one) / den;
        c[2] = big;
        c[3] = ((m12 + m21) * one) / den;
      end
      default: begin
        c[0] = ((m10 - m01) * one) / den;
        c[1] = ((m02 + m20) * one) / den;
        c[2] = ((m12 + m21) * one) / den;
        c[3] = big;
      end
    endcase
    q.w = clamp_unit(c[0]);
    q.x = clamp_unit(c[1]);
    q.y = clamp_unit(c[2]);
    q.z = clamp_unit(c[3]);
    q.br = br;
    return q;
  endfunction

  initial begin
    fail_count = 0;
    quat_count = 0;
    for (int i = 0; i < 4; i++) branch_hits[i] = 0;
  end

  assign pending_quats = expected_quats.size();

  // predict on input words, compare on output words
  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && in_valid && in_ready)
      expected_quats.push_back(shepperd(elem_r0c0, elem_r0c1, elem_r0c2,
                                        elem_r1c0, elem_r1c1, elem_r1c2,
                                        elem_r2c0, elem_r2c1, elem_r2c2));
    if (!rst && out_valid && out_ready) begin
      got = {quat_w, quat_x, quat_y, quat_z, branch_taken};
      quat_count++;
      branch_hits[branch_taken]++;
      if (expected_quats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected output word %h", got);
      end else begin
        want = expected_quats.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected w=%h x=%h y=%h z=%h br=%0d, got w=%h x=%h y=%h z=%h br=%0d",
                     want.w, want.x, want.y, want.z, want.br,
                     got.w, got.x, got.y, got.z, got.br);
        end
      end
    end
  end
endmodule

/* bench/rotation_matrix_to_quaternion_test.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Drives directed and random matrices through the block under three idle
// patterns, with a side checker predicting every quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam int LIMIT = 400000;
  localparam int ONE = 65536;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [FIELD_W-1:0] m [9];
  logic signed [FIELD_W-1:0] quat_w, quat_x, quat_y, quat_z;
  logic [1:0] branch_taken;
  int fail_count, pending_quats, quat_count;
  int branch_hits [4];
  int send_idle, recv_idle, cycles;

  initial for (int i = 0; i < 9; i++) m[i] = '0;

  always #6 clk = ~clk;

  rotation_matrix_to_quaternion dut (
    .clk, .rst, .in_valid, .in_ready,
    .elem_r0c0(m[0]), .elem_r0c1(m[1]), .elem_r0c2(m[2]),
    .elem_r1c0(m[3]), .elem_r1c1(m[4]), .elem_r1c2(m[5]),
    .elem_r2c0(m[6]), .elem_r2c1(m[7]), .elem_r2c2(m[8]),
    .out_valid, .out_ready, .quat_w, .quat_x, .quat_y, .quat_z, .branch_taken
  );

  rmq_checker chk (
    .clk, .rst, .in_valid, .in_ready,
    .elem_r0c0(m[0]), .elem_r0c1(m[1]), .elem_r0c2(m[2]),
    .elem_r1c0(m[3]), .elem_r1c1(m[4]), .elem_r1c2(m[5]),
    .elem_r2c0(m[6]), .elem_r2c1(m[7]), .elem_r2c2(m[8]),
    .out_valid, .out_ready, .quat_w, .quat_x, .quat_y, .quat_z, .branch_taken,
    .fail_count, .pending_quats, .quat_count, .branch_hits
  );

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rotation_matrix_to_quaternion_test: FAIL");
      $finish;
    end
  end

  // present one matrix after an optional idle gap, hold until taken
  task automatic send_matrix(input logic signed [FIELD_W-1:0] e [9]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    m = e;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic signed [FIELD_W-1:0] rand_elem();
    case ($urandom_range(9))
      0: return FIELD_W'($urandom);
      1: return FIELD_W'(ONE);
      2: return -FIELD_W'(ONE);
      3: return '0;
      default: return FIELD_W'($urandom_range(2 * ONE) - ONE);
    endcase
  endfunction

  // random elements, or a near-rotation: permuted signed axes, perturbed a little
  function automatic void rand_matrix(output logic signed [FIELD_W-1:0] e [9]);
    int p, s;
    for (int i = 0; i < 9; i++) e[i] = rand_elem();
    if ($urandom_range(2) != 0) begin
      p = $urandom_range(5);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++)
          e[r * 3 + c] = FIELD_W'($urandom_range(1200) - 600);
        s = (p + r * (1 + p % 2)) % 3;
        e[r * 3 + s] = $urandom_range(1) ? FIELD_W'(ONE - $urandom_range(400))
                                         : -FIELD_W'(ONE - $urandom_range(400));
      end
    end
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (pending_quats != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    logic signed [FIELD_W-1:0] e [9];
    logic signed [FIELD_W-1:0] d [9];
    cycles = 0;
    send_idle = 24;
    recv_idle = 63;
    repeat (9) @(negedge clk);
    rst <= 0;

    // directed: identity, axis flips, ties, zero trace, extremes
    for (int t = 0; t < 14; t++) begin
      for (int i = 0; i < 9; i++) d[i] = '0;
      case (t)
        0: begin d[0] = ONE; d[4] = ONE; d[8] = ONE; end
        1: begin d[0] = ONE; d[4] = -ONE; d[8] = -ONE; end
        2: begin d[0] = -ONE; d[4] = ONE; d[8] = -ONE; end
        3: begin d[0] = -ONE; d[4] = -ONE; d[8] = ONE; end
        4: ;
        5: begin d[0] = -ONE; d[4] = -ONE; d[8] = -ONE; end
        6: begin d[0] = ONE; d[4] = -ONE; end
        7: begin d[0] = -ONE; d[4] = -ONE; d[8] = -ONE;
                 d[1] = ONE; d[3] = ONE; d[5] = -ONE; d[7] = ONE; end
        8: for (int i = 0; i < 9; i++) d[i] = 18'sh1FFFF;
        9: for (int i = 0; i < 9; i++) d[i] = 18'sh20000;
        10: begin d[1] = -ONE; d[3] = ONE; d[2] = ONE; d[6] = -ONE;
                  d[5] = 18'sh1FFFF; d[7] = 18'sh20000; end
        11: begin d[0] = 5; d[4] = 5; d[8] = -10; d[1] = ONE; end
        12: begin d[0] = -ONE; d[4] = -ONE; d[8] = 18'sh1FFFF; end
        default: for (int i = 0; i < 9; i++) d[i] = (i % 2) ? 18'sh2AAAA : 18'sh15555;
      endcase
      send_matrix(d);
    end

    // random, three idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 24 : (ph == 1) ? 63 : 0;
      recv_idle = (ph == 0) ? 63 : (ph == 1) ? 24 : 0;
      for (int n = 0; n < 612; n++) begin
        rand_matrix(e);
        send_matrix(e);
      end
    end
    drain();

    $display("checked %0d quaternions; branches trace/x/y/z: %0d/%0d/%0d/%0d",
             quat_count, branch_hits[0], branch_hits[1], branch_hits[2],
             branch_hits[3]);
    if (fail_count == 0 && pending_quats == 0)
      $display("rotation_matrix_to_quaternion_test: PASS");
    else
      $display("rotation_matrix_to_quaternion_test: FAIL");
    $finish;
  end
endmodule
